/* design/assert_macros.svh */
// Assertion macros shared by the graph connectivity unit.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define UGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define UGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ugc_pkg.sv */
// Shared types and constants of the graph connectivity unit.
// No dependencies; every other design file but assert_macros.svh imports it.
package ugc_pkg;

    localparam int VID_W    = 6;           // vertex id width
    localparam int CNT_W    = VID_W + 1;   // vertex count width
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int EDGE_W   = 12;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CHECK  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // Access control from the sequencer to the adjacency memory
    typedef struct packed {
        logic             rd_en;
        logic [VID_W-1:0] rd_addr;
        logic             wr_en;
        logic [VID_W-1:0] wr_addr;
    } mem_cmd_t;

endpackage

/* design/ugc_in_if.sv */
// Input channel of the graph connectivity unit: one word per graph action.
// Depends on ugc_pkg for field widths.
interface ugc_in_if;
    import ugc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VID_W-1:0]    vertex_a;
    logic [VID_W-1:0]    vertex_b;

    modport source (output valid, action, vertex_a, vertex_b, input ready);
    modport sink   (input valid, action, vertex_a, vertex_b, output ready);
endinterface

/* design/ugc_out_if.sv */
// Output channel of the graph connectivity unit: one result word per action.
// Depends on ugc_pkg for field widths.
interface ugc_out_if;
    import ugc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                adjacent;
    logic                connected;
    logic [EDGE_W-1:0]   edge_count;

    modport source (output valid, status, adjacent, connected, edge_count, input ready);
    modport sink   (input valid, status, adjacent, connected, edge_count, output ready);
endinterface

/* design/ugc_adj_mem.sv */
// Adjacency row memory: one row of neighbour bits per vertex, one read and
// one write port, registered read. Depends on ugc_pkg for the command struct.
module ugc_adj_mem #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ugc_pkg::mem_cmd_t       cmd,
    input  logic [MAX_VERTICES-1:0] wr_row,
    output logic [MAX_VERTICES-1:0] rd_row
);
    import ugc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_hit_reg;

    // Row storage and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            adj_rows[cmd.wr_addr[IDX_W-1:0]] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= adj_rows[cmd.rd_addr[IDX_W-1:0]];
        end
    end

    // Track written rows; an unwritten row reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.wr_addr[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_hit_reg <= row_valid_reg[cmd.rd_addr[IDX_W-1:0]];
            end
        end
    end

    assign rd_row = rd_hit_reg ? rd_data_reg : '0;

endmodule

/* design/ugc_ctrl.sv */
// Sequencer of the graph connectivity unit: edge edits, adjacency queries,
// reachability search and the output register. Depends on ugc_pkg, the
// channel interfaces, assert_macros.svh and drives ugc_adj_mem.
`include "assert_macros.svh"

module ugc_ctrl #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ugc_pkg::CNT_W-1:0] vertex_limit,
    ugc_in_if.sink                  in_ch,
    ugc_out_if.source               out_ch,
    output ugc_pkg::mem_cmd_t       mem_cmd,
    output logic [MAX_VERTICES-1:0] wr_row,
    input  logic [MAX_VERTICES-1:0] rd_row
);
    import ugc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EDGE_A = 7'b0000010,
        S_READ_B = 7'b0000100,
        S_EDGE_B = 7'b0001000,
        S_PICK   = 7'b0010000,
        S_EXPAND = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ACTION_W-1:0]     act_reg, act_next;
    logic [VID_W-1:0]        va_reg, va_next;
    logic [VID_W-1:0]        vb_reg, vb_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] pending_reg, pending_next;
    logic [EDGE_W-1:0]       edge_total_reg, edge_total_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    res_adj_reg, res_adj_next;
    logic                    res_conn_reg, res_conn_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_adj_reg;
    logic                    out_conn_reg;
    logic [EDGE_W-1:0]       out_edges_reg;
    logic                    out_load;

    logic [MAX_VERTICES-1:0] in_use;
    logic [MAX_VERTICES-1:0] mask_a;
    logic [MAX_VERTICES-1:0] mask_b;
    logic [MAX_VERTICES-1:0] low_one;
    logic [MAX_VERTICES-1:0] fresh;
    logic [IDX_W-1:0]        pick_idx;
    logic                    out_of_range;
    logic                    adj_now;

    // Vertices in use, endpoint masks and the lowest pending vertex
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            in_use[i] = (CNT_W'(i) < vertex_limit);
        end
        mask_a  = MAX_VERTICES'(1) << va_reg[IDX_W-1:0];
        mask_b  = MAX_VERTICES'(1) << vb_reg[IDX_W-1:0];
        low_one = pending_reg & (~pending_reg + MAX_VERTICES'(1));
        for (int k = 0; k < IDX_W; k++)
        begin
            pick_idx[k] = 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    pick_idx[k] = pick_idx[k] | low_one[i];
                end
            end
        end
        fresh        = rd_row & in_use & ~visited_reg;
        adj_now      = |(rd_row & mask_b);
        out_of_range = ({1'b0, in_ch.vertex_a} >= vertex_limit)
                    || ({1'b0, in_ch.vertex_b} >= vertex_limit);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        visited_next    = visited_reg;
        pending_next    = pending_reg;
        edge_total_next = edge_total_reg;
        res_status_next = res_status_reg;
        res_adj_next    = res_adj_reg;
        res_conn_next   = res_conn_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_load        = 1'b0;
        mem_cmd         = '0;
        wr_row          = '0;
        in_ch.ready     = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    act_next      = in_ch.action;
                    va_next       = in_ch.vertex_a;
                    vb_next       = in_ch.vertex_b;
                    res_status_next = ST_OK;
                    res_adj_next  = 1'b0;
                    res_conn_next = 1'b0;
                    if (in_ch.action == ACT_CHECK)
                    begin
                        visited_next = MAX_VERTICES'(1);
                        pending_next = MAX_VERTICES'(1);
                        state_next   = S_PICK;
                    end
                    else if (out_of_range)
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = in_ch.vertex_a;
                        state_next      = S_EDGE_A;
                    end
                end
            end
            S_EDGE_A:
            begin
                res_adj_next = adj_now;
                state_next   = S_EMIT;
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (adj_now)
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        else
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = va_reg;
                            wr_row          = rd_row | mask_b;
                            edge_total_next = edge_total_reg + EDGE_W'(1);
                            state_next      = S_READ_B;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!adj_now)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = va_reg;
                            wr_row          = rd_row & ~mask_b;
                            edge_total_next = edge_total_reg - EDGE_W'(1);
                            state_next      = S_READ_B;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_READ_B:
            begin
                // row a is already written, so a self-loop sees its own update
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = vb_reg;
                state_next      = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = vb_reg;
                wr_row          = (act_reg == ACT_ADD) ? (rd_row | mask_a)
                                                       : (rd_row & ~mask_a);
                state_next      = S_EMIT;
            end
            S_PICK:
            begin
                if (pending_reg == '0)
                begin
                    res_conn_next = (visited_reg == in_use);
                    state_next    = S_EMIT;
                end
                else
                begin
                    pending_next    = pending_reg & ~low_one;
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = VID_W'(pick_idx);
                    state_next      = S_EXPAND;
                end
            end
            S_EXPAND:
            begin
                visited_next = visited_reg | fresh;
                pending_next = pending_reg | fresh;
                state_next   = S_PICK;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            visited_reg    <= '0;
            pending_reg    <= '0;
            edge_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            visited_reg    <= visited_next;
            pending_reg    <= pending_next;
            edge_total_reg <= edge_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Held item and result words
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        res_status_reg <= res_status_next;
        res_adj_reg    <= res_adj_next;
        res_conn_reg   <= res_conn_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_adj_reg    <= res_adj_reg;
            out_conn_reg   <= res_conn_reg;
            out_edges_reg  <= edge_total_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.adjacent   = out_adj_reg;
    assign out_ch.connected  = out_conn_reg;
    assign out_ch.edge_count = out_edges_reg;

    `UGC_ASSERT(a_no_rw_overlap, !(mem_cmd.rd_en && mem_cmd.wr_en), "read and write in one cycle")
    `UGC_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state_reg != S_IDLE, "accepted word left block idle")
    `UGC_ASSERT_NEXT(a_edges_held, state_reg != S_EDGE_A, $stable(edge_total_reg), "edge count moved outside an edit")
    `UGC_ASSERT_IMP(a_root_reached, state_reg == S_PICK || state_reg == S_EXPAND, visited_reg[0], "vertex zero not marked during search")

endmodule

/* design/undirected_graph_connectivity_unit.sv */
// Undirected graph connectivity unit. Holds up to MAX_VERTICES vertices as a
// symmetric adjacency bit memory, empty after reset (per-row valid bits, so no
// clearing pass). Each input word adds, removes or queries an edge, or checks
// whether every vertex below vertex_count is reachable from vertex zero; each
// gives one result word. Words are taken one at a time; a check reads one
// adjacency row per vertex reached from vertex zero on the single memory
// read port. A finished result waits in an output register while the next
// word is accepted. vertex_count is written through cfg_write_en and
// cfg_write_data; zero acts as one, values above MAX_VERTICES act as
// MAX_VERTICES. Depends on ugc_pkg, ugc_in_if, ugc_out_if, ugc_adj_mem
// and ugc_ctrl.
module undirected_graph_connectivity_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [ugc_pkg::CNT_W-1:0] cfg_write_data,
    ugc_in_if.sink                    in_ch,
    ugc_out_if.source                 out_ch
);
    import ugc_pkg::*;

    logic [CNT_W-1:0]        vertex_count_reg;
    logic [CNT_W-1:0]        vertex_limit;
    mem_cmd_t                mem_cmd;
    logic [MAX_VERTICES-1:0] wr_row;
    logic [MAX_VERTICES-1:0] rd_row;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            vertex_count_reg <= cfg_write_data;
        end
    end

    // Clamp the vertex count to one .. MAX_VERTICES
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            vertex_limit = CNT_W'(1);
        end
        else if (vertex_count_reg > CNT_W'(MAX_VERTICES))
        begin
            vertex_limit = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            vertex_limit = vertex_count_reg;
        end
    end

    ugc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_limit (vertex_limit),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .mem_cmd      (mem_cmd),
        .wr_row       (wr_row),
        .rd_row       (rd_row)
    );

    ugc_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mem_cmd),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

endmodule

/* verif/undirected_graph_connectivity_unit_test.sv */
// Self-checking testbench for undirected_graph_connectivity_unit: edge edits,
// adjacency queries and connectivity checks against a graph tracker.
// Depends on ugc_pkg, ugc_in_if, ugc_out_if and the unit itself.
module undirected_graph_connectivity_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ugc_pkg::*;

    localparam int VERTEX_LIMIT = 64;
    localparam int DRAIN_CYCLES = 2 * VERTEX_LIMIT + 72;

    typedef struct packed {
        status_t            status;
        logic               adjacent;
        logic               connected;
        logic [EDGE_W-1:0]  edge_count;
    } graph_result_t;

    // Shadow graph: predicts each result word and holds those still owed
    class graph_tracker;
        logic [VERTEX_LIMIT-1:0] rows [VERTEX_LIMIT];
        logic [EDGE_W-1:0]       edges;
        logic [CNT_W-1:0]        vcount;
        graph_result_t           owed_results [$];
        int                      failures;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            edges    = '0;
            vcount   = VCOUNT_RESET;
            failures = 0;
        endfunction

        // Zero acts as one vertex, anything above the limit as the limit
        function int effective_count();
            if (vcount == 0)
                return 1;
            if (vcount > VERTEX_LIMIT)
                return VERTEX_LIMIT;
            return int'(vcount);
        endfunction

        // Grow the reached set from vertex zero until it stops changing
        function logic all_reachable(int n);
            logic [VERTEX_LIMIT-1:0] in_use;
            logic [VERTEX_LIMIT-1:0] reached;
            logic [VERTEX_LIMIT-1:0] prev;
            in_use  = (n >= VERTEX_LIMIT) ? '1 : ((64'd1 << n) - 64'd1);
            reached = 64'd1;
            do
            begin
                prev = reached;
                for (int v = 0; v < VERTEX_LIMIT; v++)
                begin
                    if (reached[v])
                        reached |= rows[v] & in_use;
                end
            end while (reached != prev);
            return reached == in_use;
        endfunction

        // Random neighbour of a below n, or -1 when a has none
        function int neighbour_of(int a, int n);
            int found [$];
            for (int v = 0; v < n; v++)
            begin
                if (rows[a][v])
                    found.push_back(v);
            end
            if (found.size() == 0)
                return -1;
            return found[$urandom_range(0, found.size() - 1)];
        endfunction

        // Apply one accepted word to the shadow graph and queue its result
        function void note_word(action_t act, int a, int b);
            graph_result_t r;
            int n;
            n = effective_count();
            r.status    = ST_OK;
            r.adjacent  = 1'b0;
            r.connected = 1'b0;
            if (act == ACT_CHECK)
                r.connected = all_reachable(n);
            else if (a >= n || b >= n)
                r.status = ST_RANGE;
            else
            begin
                r.adjacent = rows[a][b];
                case (act)
                    ACT_ADD:
                    begin
                        if (r.adjacent)
                            r.status = ST_PRESENT;
                        else
                        begin
                            rows[a][b] = 1'b1;
                            rows[b][a] = 1'b1;
                            edges++;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!r.adjacent)
                            r.status = ST_ABSENT;
                        else
                        begin
                            rows[a][b] = 1'b0;
                            rows[b][a] = 1'b0;
                            edges--;
                        end
                    end
                    default: ;
                endcase
            end
            r.edge_count = edges;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        // Match a result word against the oldest one owed
        function void check_result(graph_result_t got);
            graph_result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result word expected none actual status %0d edges %0d",
                         $time, got.status, got.edge_count);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("adjacent", want.adjacent, got.adjacent);
            compare_field("connected", want.connected, got.connected);
            compare_field("edge_count", want.edge_count, got.edge_count);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_en;
    logic [CNT_W-1:0]  cfg_write_data;

    ugc_in_if  in_ch ();
    ugc_out_if out_ch ();

    graph_tracker tracker = new();
    int           items_sent = 0;
    int           burst_left = 8;

    undirected_graph_connectivity_unit #(
        .MAX_VERTICES (VERTEX_LIMIT)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: switch between always-ready and a rotating stall pattern
    initial
    begin
        int           mode_left;
        logic [7:0]   stall_pattern;
        out_ch.ready = 1'b0;
        mode_left    = 0;
        stall_pattern = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(30, 300);
                case ($urandom_range(0, 3))
                    0: stall_pattern = 8'hFF;
                    1: stall_pattern = 8'h01 << $urandom_range(0, 7);
                    default: stall_pattern = 8'($urandom_range(1, 255));
                endcase
            end
            mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            out_ch.ready <= stall_pattern[0];
        end
    end

    // Check every result word taken by the receiver
    always @(posedge clk)
    begin
        graph_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.status     = status_t'(out_ch.status);
            got.adjacent   = out_ch.adjacent;
            got.connected  = out_ch.connected;
            got.edge_count = out_ch.edge_count;
            tracker.check_result(got);
        end
    end

    // Offer one word, hold it until taken, then maybe end the burst
    task automatic send_word(action_t act, int a, int b);
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.vertex_a <= VID_W'(a);
        in_ch.vertex_b <= VID_W'(b);
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.note_word(act, a & 63, b & 63);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Drop valid and hold until every owed result has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [CNT_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        tracker.vcount = value;
    endtask

    function automatic int pick_vertex(int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, n - 1);
    endfunction

    // Corner cases: duplicates, absences, self-loops, range errors, count limits
    task automatic directed_words();
        send_word(ACT_CHECK, 63, 63);
        send_word(ACT_ADD, 0, 63);
        send_word(ACT_ADD, 0, 63);
        send_word(ACT_ADD, 63, 0);
        send_word(ACT_QUERY, 63, 0);
        send_word(ACT_QUERY, 1, 2);
        send_word(ACT_REMOVE, 1, 2);
        send_word(ACT_ADD, 5, 5);
        send_word(ACT_QUERY, 5, 5);
        send_word(ACT_REMOVE, 5, 5);
        send_word(ACT_REMOVE, 63, 0);
        send_word(ACT_ADD, 42, 21);
        wait_drained();
        // shrink the count: the stored edge between 42 and 21 stays counted
        write_vertex_count(7'd3);
        send_word(ACT_ADD, 0, 1);
        send_word(ACT_ADD, 1, 2);
        send_word(ACT_CHECK, 0, 0);
        send_word(ACT_ADD, 3, 0);
        send_word(ACT_QUERY, 0, 63);
        send_word(ACT_REMOVE, 42, 21);
        wait_drained();
        write_vertex_count(7'd0);
        send_word(ACT_CHECK, 21, 42);
        send_word(ACT_ADD, 0, 0);
        send_word(ACT_ADD, 0, 1);
        send_word(ACT_REMOVE, 0, 0);
        wait_drained();
        write_vertex_count(7'd127);
        send_word(ACT_CHECK, 0, 0);
        send_word(ACT_ADD, 63, 63);
        send_word(ACT_REMOVE, 63, 63);
    endtask

    // Link all vertices in shuffled order, check, cut one link, check, mend it
    task automatic chain_run(int n);
        int order [VERTEX_LIMIT];
        int j;
        int t;
        int cut;
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < n - 1; i++)
            send_word(ACT_ADD, order[i], order[i + 1]);
        send_word(ACT_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
        if (n > 1)
        begin
            cut = $urandom_range(0, n - 2);
            send_word(ACT_REMOVE, order[cut + 1], order[cut]);
            send_word(ACT_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
            send_word(ACT_ADD, order[cut], order[cut + 1]);
        end
    endtask

    task automatic random_word(int n);
        int k;
        int a;
        int b;
        k = $urandom_range(0, 99);
        a = pick_vertex(n);
        b = pick_vertex(n);
        if (k < 35)
            send_word(ACT_ADD, a, b);
        else if (k < 55)
        begin
            // aim at an edge that is really there
            a = $urandom_range(0, n - 1);
            b = tracker.neighbour_of(a, n);
            send_word(ACT_REMOVE, a, (b < 0) ? pick_vertex(n) : b);
        end
        else if (k < 65)
            send_word(ACT_REMOVE, a, b);
        else if (k < 80)
            send_word(ACT_QUERY, a, b);
        else
            send_word(ACT_CHECK, a, b);
    endtask

    // Reset, directed words, then random phases each under a fresh vertex count
    initial
    begin
        logic [CNT_W-1:0] count;
        int               phase_len;
        int               n;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_ch.valid    = 1'b0;
        in_ch.action   = ACT_ADD;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        while (items_sent < 2025)
        begin
            case ($urandom_range(0, 15))
                0:       count = 7'd0;
                1:       count = 7'd1;
                2:       count = 7'd64;
                3:       count = 7'($urandom_range(65, 127));
                4:       count = 7'd127;
                5, 6:    count = 7'($urandom_range(17, 64));
                default: count = 7'($urandom_range(2, 16));
            endcase
            wait_drained();
            write_vertex_count(count);
            n = tracker.effective_count();
            if ($urandom_range(0, 2) == 0)
                chain_run(n);
            phase_len = $urandom_range(40, 160);
            for (int i = 0; i < phase_len; i++)
                random_word(n);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
